// ----- rtl/core/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// shared constants and codes for the stack machine integer unit
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned LOCAL_COUNT_DEF = 256;

  typedef enum logic [3:0] {
    ACT_PUSH  = 4'd0,
    ACT_LOAD  = 4'd1,
    ACT_STORE = 4'd2,
    ACT_SET   = 4'd3,
    ACT_ADD   = 4'd4,
    ACT_SUB   = 4'd5,
    ACT_MUL   = 4'd6,
    ACT_DIV   = 4'd7,
    ACT_MOD   = 4'd8,
    ACT_INC   = 4'd9,
    ACT_DEC   = 4'd10,
    ACT_NEG   = 4'd11,
    ACT_BEQ   = 4'd12,
    ACT_NOP13 = 4'd13,
    ACT_NOP14 = 4'd14,
    ACT_NOP15 = 4'd15
  } action_t;

  localparam logic [1:0] SRC_STACK = 2'd0;
  localparam logic [1:0] SRC_LOCAL = 2'd1;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_INDEX = 3'd4;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/core/svm_divider.sv -----
// ----------------------------------------------------------------------------
// svm_divider
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svm_divider (
  input  logic              clk,
  input  logic              rst,
  input  svm_pkg::div_req_t req,
  output svm_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 6'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        quo   <= req.dividend;
        rem   <= 32'd0;
        dvs   <= req.divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

// ----- rtl/core/stack_vm_integer_unit.sv -----
// ----------------------------------------------------------------------------
// stack_vm_integer_unit
// executes one integer stack machine instruction per item
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: action, first_source, first_value, second_source,
//               second_value, result_to_local, result_index, keep_on_stack,
//               jump_target
// m_axis   out  tdata: result_value, branch_taken, branch_target, error,
//               stack_depth
//
// accept (idle), read two stack entries and both locals (read), then compute and
// write back (execute); the next item is accepted only after write-back.
// mul adds the mul and div states; div and mod wait in the div state for the serial divider.
// after reset, the clear state zeroes every local before the first item.
// an output item still waiting holds the next item before its execute cycle.
// ----------------------------------------------------------------------------
module stack_vm_integer_unit #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LOCAL_COUNT = svm_pkg::LOCAL_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[3:0] first_source[5:4] first_value[37:6] second_source[39:38]
  // second_value[71:40] result_to_local[72] result_index[80:73]
  // keep_on_stack[81] jump_target[97:82]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0] branch_taken[32] branch_target[48:33] error[51:49]
  // stack_depth[60:52]
  output logic [63:0]  m_axis_tdata
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV} state_t;

  state_t state;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] local_mem [LOCAL_COUNT];
  logic [31:0] stk_rd0, stk_rd1, loc_rd0, loc_rd1;
  logic [LAW-1:0] clr_addr;
  logic [SPW-1:0] sp;

  logic [3:0]  act;
  logic [1:0]  src1, src2;
  logic [31:0] val1, val2;
  logic        to_local, keep;
  logic [7:0]  ridx;
  logic [15:0] jt;

  // decoded sources (read addresses)
  logic        s1_stk, s2_stk, s1_idx_bad, s2_idx_bad, v1_bad, ridx_bad;
  logic [SPW-1:0] sp_m1, sp_m2;

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);

  // stack reads, locals: two read ports
  logic [SAW-1:0] sra0, sra1;
  logic [LAW-1:0] lra0, lra1;
  assign sra0 = sp_m1[SAW-1:0];
  assign sra1 = sp_m2[SAW-1:0];
  assign lra0 = val1[LAW-1:0];
  assign lra1 = val2[LAW-1:0];

  always_ff @(posedge clk) begin
    stk_rd0 <= stack_mem[sra0];
    stk_rd1 <= stack_mem[sra1];
    loc_rd0 <= local_mem[lra0];
    loc_rd1 <= local_mem[lra1];
  end

  // operand resolve
  logic [31:0] a, b, r;
  logic [SPW-1:0] sp_after;
  logic [2:0]  err;
  logic        push_res, write_loc, is_bin, is_un, is_div;
  logic [LAW-1:0] widx;

  always_comb begin
    s1_stk    = (src1 == svm_pkg::SRC_STACK);
    s2_stk    = (src2 == svm_pkg::SRC_STACK);
    v1_bad    = (val1 >= 32'(LOCAL_COUNT));
    s1_idx_bad = (src1 == svm_pkg::SRC_LOCAL) && v1_bad;
    s2_idx_bad = (src2 == svm_pkg::SRC_LOCAL) && (val2 >= 32'(LOCAL_COUNT));
    ridx_bad  = ({24'd0, ridx} >= 32'(LOCAL_COUNT));
    is_bin = 1'b0; is_un = 1'b0; is_div = 1'b0;
    unique case (svm_pkg::action_t'(act))
      svm_pkg::ACT_ADD, svm_pkg::ACT_SUB, svm_pkg::ACT_MUL,
      svm_pkg::ACT_BEQ: is_bin = 1'b1;
      svm_pkg::ACT_DIV, svm_pkg::ACT_MOD: begin
        is_bin = 1'b1; is_div = 1'b1;
      end
      svm_pkg::ACT_INC, svm_pkg::ACT_DEC, svm_pkg::ACT_NEG: is_un = 1'b1;
      default: ;
    endcase
    err = svm_pkg::ERR_OK;
    sp_after = sp;
    a = val1; b = val2;
    if (is_bin || is_un) begin
      if (s1_stk) begin
        if (sp == '0) err = svm_pkg::ERR_UNDER;
        else begin a = stk_rd0; sp_after = sp_m1; end
      end else if (s1_idx_bad) err = svm_pkg::ERR_INDEX;
      else if (src1 == svm_pkg::SRC_LOCAL) a = loc_rd0;
      if (is_bin && err == svm_pkg::ERR_OK) begin
        if (s2_stk) begin
          if (sp_after == '0) err = svm_pkg::ERR_UNDER;
          else begin
            b = s1_stk ? stk_rd1 : stk_rd0;
            sp_after = sp_after - SPW'(1);
          end
        end else if (s2_idx_bad) err = svm_pkg::ERR_INDEX;
        else if (src2 == svm_pkg::SRC_LOCAL) b = loc_rd1;
      end
    end
  end

  logic [31:0] ua, ub;
  assign ua = a[31] ? 32'd0 - a : a;
  assign ub = b[31] ? 32'd0 - b : b;

  svm_pkg::div_req_t dreq;
  svm_pkg::div_rsp_t drsp;
  svm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [31:0] ha, hb, prod;
  logic        neg_q, neg_r;
  logic [SPW-1:0] hsp;
  logic [2:0]  herr;

  // output item register
  logic [31:0] o_val;
  logic        o_tk;
  logic [15:0] o_tg;
  logic [2:0]  o_err;
  logic [SPW-1:0] o_sp;

  always_comb begin
    r = 32'd0;
    push_res = 1'b0; write_loc = 1'b0; widx = LAW'(ridx);
    unique case (svm_pkg::action_t'(act))
      svm_pkg::ACT_ADD: r = a + b;
      svm_pkg::ACT_SUB: r = a - b;
      svm_pkg::ACT_INC: r = a + 32'd1;
      svm_pkg::ACT_DEC: r = a - 32'd1;
      svm_pkg::ACT_NEG: r = 32'd0 - a;
      default: ;
    endcase
    if ((is_bin || is_un) && act != svm_pkg::ACT_BEQ) begin
      push_res = !to_local; write_loc = to_local;
    end
  end

  // finish in the execute state
  logic [SPW-1:0] fsp;
  logic [31:0] fval;
  logic [2:0]  ferr;
  logic        fpush, floc, ftk;
  logic [LAW-1:0] fidx;

  always_comb begin
    fsp = sp_after; fval = r; ferr = err; fpush = push_res;
    floc = write_loc; ftk = 1'b0; fidx = widx;
    unique case (svm_pkg::action_t'(act))
      svm_pkg::ACT_PUSH: begin fval = val1; fpush = 1'b1; end
      svm_pkg::ACT_LOAD: begin
        fpush = 1'b1;
        if (v1_bad) ferr = svm_pkg::ERR_INDEX; else fval = loc_rd0;
      end
      svm_pkg::ACT_STORE: begin
        if (sp == '0) ferr = svm_pkg::ERR_UNDER;
        else begin
          fval = stk_rd0;
          if (!keep) fsp = sp_m1;
          if (v1_bad) ferr = svm_pkg::ERR_INDEX;
          else begin floc = 1'b1; fidx = val1[LAW-1:0]; end
        end
      end
      svm_pkg::ACT_SET: begin
        if (v1_bad) ferr = svm_pkg::ERR_INDEX;
        else begin fval = val2; floc = 1'b1; fidx = val1[LAW-1:0]; end
      end
      svm_pkg::ACT_BEQ: ftk = (a == b);
      svm_pkg::ACT_DIV, svm_pkg::ACT_MOD:
        if (err == svm_pkg::ERR_OK) ferr = svm_pkg::ERR_DIVZ;
      default: ;
    endcase
    if (ferr == svm_pkg::ERR_OK && floc && to_local && ridx_bad
        && (is_un || is_bin)) ferr = svm_pkg::ERR_INDEX;
    if (ferr == svm_pkg::ERR_OK && fpush && fsp >= SP_FULL)
      ferr = svm_pkg::ERR_OVER;
  end

  // mul, div and mod finish
  logic [31:0] hval;
  logic [2:0]  herr_fin;

  always_comb begin
    if (act == svm_pkg::ACT_MUL) hval = prod;
    else if (act == svm_pkg::ACT_DIV)
      hval = neg_q ? 32'd0 - drsp.quotient : drsp.quotient;
    else hval = neg_r ? 32'd0 - drsp.remainder : drsp.remainder;
    herr_fin = herr;
    if (herr_fin == svm_pkg::ERR_OK && to_local && ridx_bad)
      herr_fin = svm_pkg::ERR_INDEX;
    if (herr_fin == svm_pkg::ERR_OK && !to_local && hsp >= SP_FULL)
      herr_fin = svm_pkg::ERR_OVER;
  end

  logic div_go, exec_fin, long_fin, out_load;
  assign div_go   = is_div && (err == svm_pkg::ERR_OK) && (b != 32'd0);
  assign exec_fin = (state == S_EXEC) && (act != svm_pkg::ACT_MUL) && !div_go;
  assign long_fin = (state == S_DIV) && ((act == svm_pkg::ACT_MUL) || drsp.done);
  assign out_load = exec_fin || long_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      sp <= '0;
      s_axis_tready <= 1'b0;
      m_axis_tvalid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          local_mem[clr_addr] <= 32'd0;
          clr_addr <= clr_addr + LAW'(1);
          if (clr_addr == LAW'(LOCAL_COUNT - 1)) begin
            state <= S_IDLE; s_axis_tready <= 1'b1;
          end
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          act <= s_axis_tdata[3:0];
          src1 <= s_axis_tdata[5:4];
          val1 <= s_axis_tdata[37:6];
          src2 <= s_axis_tdata[39:38];
          val2 <= s_axis_tdata[71:40];
          to_local <= s_axis_tdata[72];
          ridx <= s_axis_tdata[80:73];
          keep <= s_axis_tdata[81];
          jt <= s_axis_tdata[97:82];
          s_axis_tready <= 1'b0;
          state <= S_READ;
        end
        S_READ: if (!m_axis_tvalid || m_axis_tready) state <= S_EXEC;
        S_EXEC: begin
          ha <= a; hb <= b; hsp <= sp_after; herr <= err;
          neg_q <= a[31] ^ b[31]; neg_r <= a[31];
          if (act == svm_pkg::ACT_MUL) state <= S_MUL;
          else if (div_go) begin
            dreq.start <= 1'b1; dreq.dividend <= ua; dreq.divisor <= ub;
            state <= S_DIV;
          end else begin
            if (ferr == svm_pkg::ERR_OK) begin
              if (fpush) begin
                stack_mem[fsp[SAW-1:0]] <= fval;
                sp <= fsp + SPW'(1); o_sp <= fsp + SPW'(1);
              end else begin
                sp <= fsp; o_sp <= fsp;
              end
              if (floc) local_mem[fidx] <= fval;
              o_val <= fval; o_tk <= ftk; o_tg <= ftk ? jt : 16'd0;
            end else begin
              o_val <= 32'd0; o_tk <= 1'b0; o_tg <= 16'd0; o_sp <= sp;
            end
            o_err <= ferr;
            state <= S_IDLE; s_axis_tready <= 1'b1;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: if (long_fin) begin
          if (herr_fin == svm_pkg::ERR_OK) begin
            if (to_local) begin
              local_mem[LAW'(ridx)] <= hval; sp <= hsp; o_sp <= hsp;
            end else begin
              stack_mem[hsp[SAW-1:0]] <= hval;
              sp <= hsp + SPW'(1); o_sp <= hsp + SPW'(1);
            end
            o_val <= hval;
          end else begin
            o_val <= 32'd0; o_sp <= sp;
          end
          o_tk <= 1'b0; o_tg <= 16'd0; o_err <= herr_fin;
          state <= S_IDLE; s_axis_tready <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) prod <= ha * hb;

  assign m_axis_tdata = {3'd0, 9'(o_sp), o_err, o_tg, o_tk, o_val};

endmodule
